@@ rtl/kts_pkg.sv @@
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types, constants and keyword tables of the keyword token scanner.
// ----------------------------------------------------------------------------
package kts_pkg;

	localparam int LINE_BITS      = 16;
	localparam int OFFSET_BITS    = 20;
	localparam int KEYWORD_CHARS  = 6;
	localparam int PREFIX_BITS    = 8 * KEYWORD_CHARS;
	localparam int NUM_KEYWORDS   = 7;
	localparam int KW_MAX_CHARS   = 8;
	localparam int MAX_RESULTS    = 3;
	localparam int PUSH_BITS      = $clog2(MAX_RESULTS + 1);
	localparam int QUEUE_DEPTH    = 8;
	localparam int PTR_BITS       = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS       = PTR_BITS + 1;

	typedef enum logic [4:0] {
		KIND_NEWLINE = 5'd0,
		KIND_NUMBER  = 5'd1,
		KIND_IDENT   = 5'd2,
		KIND_LET     = 5'd3,
		KIND_CONST   = 5'd4,
		KIND_OUT     = 5'd5,
		KIND_IF      = 5'd6,
		KIND_ELSE    = 5'd7,
		KIND_REPEAT  = 5'd8,
		KIND_TIMES   = 5'd9,
		KIND_STRING  = 5'd10,
		KIND_PLUS    = 5'd11,
		KIND_MINUS   = 5'd12,
		KIND_STAR    = 5'd13,
		KIND_SLASH   = 5'd14,
		KIND_GT      = 5'd15,
		KIND_LT      = 5'd16,
		KIND_EQ      = 5'd17,
		KIND_EQEQ    = 5'd18,
		KIND_LPAREN  = 5'd19,
		KIND_RPAREN  = 5'd20,
		KIND_LBRACE  = 5'd21,
		KIND_RBRACE  = 5'd22,
		KIND_SEMI    = 5'd23,
		KIND_END     = 5'd24,
		KIND_ERROR   = 5'd25
	} kind_t;

	typedef enum logic [5:0] {
		MODE_IDLE   = 6'b000001,
		MODE_NUMBER = 6'b000010,
		MODE_WORD   = 6'b000100,
		MODE_STRING = 6'b001000,
		MODE_EQUAL  = 6'b010000,
		MODE_HALTED = 6'b100000
	} mode_t;

	typedef struct packed {
		mode_t                  mode;
		logic                   quote_single;
		logic [PREFIX_BITS-1:0] prefix;
		logic                   too_long;
		logic [LINE_BITS-1:0]   tok_line;
		logic [LINE_BITS-1:0]   tok_col;
		logic [OFFSET_BITS-1:0] tok_off;
		logic [OFFSET_BITS-1:0] tok_len;
		logic [LINE_BITS-1:0]   cur_line;
		logic [LINE_BITS-1:0]   cur_col;
		logic [OFFSET_BITS-1:0] cur_off;
	} scan_state_t;

	localparam scan_state_t RESET_STATE = '{
		mode:         MODE_IDLE,
		quote_single: 1'b0,
		prefix:       '0,
		too_long:     1'b0,
		tok_line:     LINE_BITS'(1),
		tok_col:      LINE_BITS'(1),
		tok_off:      '0,
		tok_len:      '0,
		cur_line:     LINE_BITS'(1),
		cur_col:      LINE_BITS'(1),
		cur_off:      '0
	};

	typedef struct packed {
		kind_t                  kind;
		logic [LINE_BITS-1:0]   line;
		logic [LINE_BITS-1:0]   column;
		logic [OFFSET_BITS-1:0] offset;
		logic [OFFSET_BITS-1:0] length;
		logic                   last;
	} tok_rec_t;

	typedef struct packed {
		logic [PUSH_BITS-1:0] push_n;
		logic                 halted;
	} scan_status_t;

	typedef struct packed {
		logic [CNT_BITS-1:0] count;
		logic                room;
	} queue_status_t;

	// keyword text, first character in the low byte
	localparam logic [8*KW_MAX_CHARS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
		64'h0000_0000_0074_656c,
		64'h0000_0074_736e_6f63,
		64'h0000_0000_0074_756f,
		64'h0000_0000_0000_6669,
		64'h0000_0000_6573_6c65,
		64'h0000_7461_6570_6572,
		64'h0000_0073_656d_6974
	};

	localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
		4'd3, 4'd5, 4'd3, 4'd2, 4'd4, 4'd6, 4'd5
	};

	localparam kind_t KW_KIND [NUM_KEYWORDS] = '{
		KIND_LET, KIND_CONST, KIND_OUT, KIND_IF, KIND_ELSE, KIND_REPEAT, KIND_TIMES
	};

	function automatic kind_t word_kind(input logic [PREFIX_BITS-1:0] prefix,
			input logic too_long, input logic [OFFSET_BITS-1:0] len);
		kind_t k;
		logic  same;
		k = KIND_IDENT;
		if (!too_long && len <= OFFSET_BITS'(KEYWORD_CHARS)) begin
			for (int w = NUM_KEYWORDS - 1; w >= 0; w--) begin
				same = (len == OFFSET_BITS'(KW_LEN[w])) && (int'(KW_LEN[w]) <= KEYWORD_CHARS);
				for (int i = 0; i < KEYWORD_CHARS; i++) begin
					if (i < int'(KW_LEN[w]) && prefix[8*i +: 8] != KW_TEXT[w][8*i +: 8]) begin
						same = 1'b0;
					end
				end
				if (same) begin
					k = KW_KIND[w];
				end
			end
		end
		return k;
	endfunction

	// error kind means no single-character operator
	function automatic kind_t op_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			"+": k = KIND_PLUS;
			"-": k = KIND_MINUS;
			"*": k = KIND_STAR;
			"/": k = KIND_SLASH;
			">": k = KIND_GT;
			"<": k = KIND_LT;
			"(": k = KIND_LPAREN;
			")": k = KIND_RPAREN;
			"{": k = KIND_LBRACE;
			"}": k = KIND_RBRACE;
			";": k = KIND_SEMI;
			default: k = KIND_ERROR;
		endcase
		return k;
	endfunction

endpackage

@@ rtl/kts_scan.sv @@
// ----------------------------------------------------------------------------
// kts_scan
// Scanner state register and per-word next-state and token record logic.
// ----------------------------------------------------------------------------
module kts_scan (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic [7:0]                                    src_byte,
	input  logic                                          src_final,
	input  logic                                          fire,
	output kts_pkg::tok_rec_t [kts_pkg::MAX_RESULTS-1:0] recs,
	output kts_pkg::scan_status_t                         status
);

	kts_pkg::scan_state_t state_q;
	kts_pkg::scan_state_t nx;
	kts_pkg::tok_rec_t    cand [4];
	logic [3:0]           cand_v;
	logic [kts_pkg::PUSH_BITS-1:0] n;
	logic                 dispatch;
	logic                 halt_now;
	logic                 is_digit;
	logic                 is_alpha;
	logic                 is_space;
	logic [7:0]           quote;

	function automatic logic [kts_pkg::LINE_BITS-1:0] sat_line(
			input logic [kts_pkg::LINE_BITS-1:0] v);
		return (&v) ? v : v + kts_pkg::LINE_BITS'(1);
	endfunction

	function automatic logic [kts_pkg::OFFSET_BITS-1:0] sat_off(
			input logic [kts_pkg::OFFSET_BITS-1:0] v);
		return (&v) ? v : v + kts_pkg::OFFSET_BITS'(1);
	endfunction

	function automatic kts_pkg::tok_rec_t mk_rec(input kts_pkg::kind_t kind,
			input logic [kts_pkg::LINE_BITS-1:0] line,
			input logic [kts_pkg::LINE_BITS-1:0] col,
			input logic [kts_pkg::OFFSET_BITS-1:0] off,
			input logic [kts_pkg::OFFSET_BITS-1:0] len);
		kts_pkg::tok_rec_t r;
		r.kind   = kind;
		r.line   = line;
		r.column = col;
		r.offset = off;
		r.length = len;
		r.last   = 1'b0;
		return r;
	endfunction

	function automatic logic pending(input kts_pkg::scan_state_t st);
		return st.mode == kts_pkg::MODE_NUMBER || st.mode == kts_pkg::MODE_WORD ||
			st.mode == kts_pkg::MODE_STRING || st.mode == kts_pkg::MODE_EQUAL;
	endfunction

	function automatic kts_pkg::tok_rec_t flush_rec(input kts_pkg::scan_state_t st);
		kts_pkg::kind_t k;
		case (st.mode)
			kts_pkg::MODE_NUMBER: k = kts_pkg::KIND_NUMBER;
			kts_pkg::MODE_WORD:   k = kts_pkg::word_kind(st.prefix, st.too_long, st.tok_len);
			kts_pkg::MODE_STRING: k = kts_pkg::KIND_STRING;
			default:              k = kts_pkg::KIND_EQ;
		endcase
		return mk_rec(k, st.tok_line, st.tok_col, st.tok_off, st.tok_len);
	endfunction

	assign is_digit = src_byte >= "0" && src_byte <= "9";
	assign is_alpha = (src_byte >= "a" && src_byte <= "z") || (src_byte >= "A" && src_byte <= "Z");
	assign is_space = src_byte == " " || src_byte == 8'h09 || src_byte == 8'h0a ||
		src_byte == 8'h0d || src_byte == 8'h0b || src_byte == 8'h0c;
	assign quote    = state_q.quote_single ? 8'h27 : 8'h22;

	always_comb begin
		nx       = state_q;
		cand_v   = '0;
		dispatch = 1'b0;
		halt_now = 1'b0;
		cand[0]  = flush_rec(state_q);
		cand[1]  = mk_rec(kts_pkg::KIND_NEWLINE, state_q.cur_line, state_q.cur_col,
			state_q.cur_off, kts_pkg::OFFSET_BITS'(1));
		cand[2]  = cand[0];
		cand[3]  = mk_rec(kts_pkg::KIND_END, state_q.cur_line, state_q.cur_col,
			state_q.cur_off, '0);

		if (state_q.mode == kts_pkg::MODE_HALTED) begin
			nx = state_q;
		end else if (src_byte == 8'h00) begin
			// zero byte is not consumed: flush, then end at its position
			cand_v[0] = pending(state_q);
			cand_v[3] = 1'b1;
			nx        = kts_pkg::RESET_STATE;
		end else begin
			case (state_q.mode)
				kts_pkg::MODE_NUMBER: begin
					if (is_digit) begin
						nx.tok_len = sat_off(state_q.tok_len);
					end else begin
						cand_v[0] = 1'b1;
						dispatch  = 1'b1;
					end
				end
				kts_pkg::MODE_WORD: begin
					if (is_digit || is_alpha) begin
						if (!state_q.too_long &&
								state_q.tok_len < kts_pkg::OFFSET_BITS'(kts_pkg::KEYWORD_CHARS)) begin
							for (int i = 0; i < kts_pkg::KEYWORD_CHARS; i++) begin
								if (state_q.tok_len == kts_pkg::OFFSET_BITS'(i)) begin
									nx.prefix[8*i +: 8] = src_byte;
								end
							end
						end else begin
							nx.too_long = 1'b1;
						end
						nx.tok_len = sat_off(state_q.tok_len);
					end else begin
						cand_v[0] = 1'b1;
						dispatch  = 1'b1;
					end
				end
				kts_pkg::MODE_STRING: begin
					if (src_byte == quote) begin
						cand_v[0] = 1'b1;
						nx.mode   = kts_pkg::MODE_IDLE;
					end else begin
						nx.tok_len = sat_off(state_q.tok_len);
					end
				end
				kts_pkg::MODE_EQUAL: begin
					cand_v[0] = 1'b1;
					if (src_byte == "=") begin
						cand[0].kind   = kts_pkg::KIND_EQEQ;
						cand[0].length = kts_pkg::OFFSET_BITS'(2);
						nx.mode        = kts_pkg::MODE_IDLE;
					end else begin
						dispatch = 1'b1;
					end
				end
				default: begin
					dispatch = 1'b1;
				end
			endcase

			if (dispatch) begin
				nx.mode = kts_pkg::MODE_IDLE;
				if (is_space) begin
					cand_v[1] = src_byte == 8'h0a;
				end else if (is_digit || is_alpha || src_byte == 8'h22 ||
						src_byte == 8'h27 || src_byte == "=") begin
					// new token starts at the current position
					nx.tok_line = state_q.cur_line;
					nx.tok_col  = state_q.cur_col;
					nx.tok_off  = state_q.cur_off;
					nx.prefix   = '0;
					nx.too_long = 1'b0;
					nx.tok_len  = kts_pkg::OFFSET_BITS'(1);
					if (is_digit) begin
						nx.mode = kts_pkg::MODE_NUMBER;
					end else if (is_alpha) begin
						nx.prefix = kts_pkg::PREFIX_BITS'(src_byte);
						nx.mode   = kts_pkg::MODE_WORD;
					end else if (src_byte == "=") begin
						nx.mode = kts_pkg::MODE_EQUAL;
					end else begin
						nx.tok_len      = '0;
						nx.quote_single = src_byte == 8'h27;
						nx.mode         = kts_pkg::MODE_STRING;
					end
				end else begin
					cand_v[1]    = 1'b1;
					cand[1].kind = kts_pkg::op_kind(src_byte);
					if (cand[1].kind == kts_pkg::KIND_ERROR) begin
						halt_now = 1'b1;
						nx.mode  = kts_pkg::MODE_HALTED;
					end
				end
			end

			if (!halt_now) begin
				if (src_byte == 8'h0a) begin
					nx.cur_line = sat_line(state_q.cur_line);
					nx.cur_col  = kts_pkg::LINE_BITS'(1);
				end else begin
					nx.cur_col = sat_line(state_q.cur_col);
				end
				nx.cur_off = sat_off(state_q.cur_off);

				if (src_final) begin
					// flush what this word left open, end after the word
					cand_v[2] = pending(nx);
					cand[2]   = flush_rec(nx);
					cand_v[3] = 1'b1;
					cand[3]   = mk_rec(kts_pkg::KIND_END, nx.cur_line, nx.cur_col,
						nx.cur_off, '0);
					nx        = kts_pkg::RESET_STATE;
				end
			end
		end
	end

	// pack the valid candidates in order
	always_comb begin
		recs = '0;
		n    = '0;
		for (int j = 0; j < 4; j++) begin
			if (cand_v[j] && n < kts_pkg::PUSH_BITS'(kts_pkg::MAX_RESULTS)) begin
				recs[n] = cand[j];
				n       = n + kts_pkg::PUSH_BITS'(1);
			end
		end
		if (n != '0) begin
			recs[n - kts_pkg::PUSH_BITS'(1)].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kts_pkg::RESET_STATE;
		end else if (fire) begin
			state_q <= nx;
		end
	end

	assign status.push_n = fire ? n : '0;
	assign status.halted = state_q.mode == kts_pkg::MODE_HALTED;

endmodule

@@ rtl/kts_queue.sv @@
// ----------------------------------------------------------------------------
// kts_queue
// Token record queue: takes up to three records a cycle, hands out one.
// ----------------------------------------------------------------------------
module kts_queue (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic [kts_pkg::PUSH_BITS-1:0]                 push_n,
	input  kts_pkg::tok_rec_t [kts_pkg::MAX_RESULTS-1:0] recs,
	input  logic                                          pop_ready,
	output logic                                          head_valid,
	output kts_pkg::tok_rec_t                             head,
	output kts_pkg::queue_status_t                        status
);

	kts_pkg::tok_rec_t             mem_q [kts_pkg::QUEUE_DEPTH];
	logic [kts_pkg::PTR_BITS-1:0]  wr_ptr_q;
	logic [kts_pkg::PTR_BITS-1:0]  rd_ptr_q;
	logic [kts_pkg::CNT_BITS-1:0]  count_q;
	logic                          pop;

	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign pop        = head_valid && pop_ready;

	always_ff @(posedge clk) begin
		for (int i = 0; i < kts_pkg::MAX_RESULTS; i++) begin
			if (kts_pkg::PUSH_BITS'(i) < push_n) begin
				mem_q[wr_ptr_q + kts_pkg::PTR_BITS'(i)] <= recs[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + kts_pkg::PTR_BITS'(push_n);
			rd_ptr_q <= rd_ptr_q + kts_pkg::PTR_BITS'(pop);
			count_q  <= count_q + kts_pkg::CNT_BITS'(push_n) - kts_pkg::CNT_BITS'(pop);
		end
	end

	// room for a full burst regardless of this cycle's pop
	assign status.count = count_q;
	assign status.room  = count_q <=
		kts_pkg::CNT_BITS'(kts_pkg::QUEUE_DEPTH - kts_pkg::MAX_RESULTS);

endmodule

@@ rtl/keyword_token_scanner_top.sv @@
// ----------------------------------------------------------------------------
// keyword_token_scanner_top
// Byte-stream tokenizer emitting kind, position, offset and length records.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry one source word (source_byte,
// final_byte). A zero byte or final_byte ends the source and emits END.
// Output channel: out_valid/out_ready carry one token record per transfer;
// last_of_run marks the final record caused by one source word.
// Each accepted word is held in an input register and scanned from it
// once the queue has room; its records land in an eight-entry queue,
// and the first record is visible once the queue has registered it.
// Throughput is one source word per cycle while each word yields at most
// one record and out_ready is high; a word yielding up to three records
// drains at one record per cycle while out_ready is high, and the scanner
// waits while the queue has fewer than three free entries.
// Reset clears the scanner to line 1, column 1, offset 0 and empties the
// queue. After an error token the scanner keeps accepting words but emits
// nothing until reset. A stalled receiver fills the queue and then holds
// in_ready low; nothing is dropped.
// ----------------------------------------------------------------------------
module keyword_token_scanner_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        source_byte,
	input  logic                              final_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [4:0]                        token_kind,
	output logic [kts_pkg::LINE_BITS-1:0]     start_line,
	output logic [kts_pkg::LINE_BITS-1:0]     start_column,
	output logic [kts_pkg::OFFSET_BITS-1:0]   start_offset,
	output logic [kts_pkg::OFFSET_BITS-1:0]   text_length,
	output logic                              last_of_run
);

	logic                                          valid_s1;
	logic [7:0]                                    byte_s1;
	logic                                          final_s1;
	logic                                          fire;
	kts_pkg::tok_rec_t [kts_pkg::MAX_RESULTS-1:0] recs;
	kts_pkg::scan_status_t                         scan_stat;
	kts_pkg::queue_status_t                        q_stat;
	kts_pkg::tok_rec_t                             head;

	assign fire     = valid_s1 && q_stat.room;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= source_byte;
			final_s1 <= final_byte;
		end
	end

	kts_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_byte  (byte_s1),
		.src_final (final_s1),
		.fire      (fire),
		.recs      (recs),
		.status    (scan_stat)
	);

	kts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (scan_stat.push_n),
		.recs       (recs),
		.pop_ready  (out_ready),
		.head_valid (out_valid),
		.head       (head),
		.status     (q_stat)
	);

	assign token_kind   = head.kind;
	assign start_line   = head.line;
	assign start_column = head.column;
	assign start_offset = head.offset;
	assign text_length  = head.length;
	assign last_of_run  = head.last;

`ifndef SYNTH
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= kts_pkg::CNT_BITS'(kts_pkg::QUEUE_DEPTH))
		else $error("token queue overflow");

	a_halted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		scan_stat.halted |-> scan_stat.push_n == '0)
		else $error("records pushed while halted");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_stat.push_n != '0 && !(out_valid && out_ready)) |=>
		q_stat.count == $past(q_stat.count) + kts_pkg::CNT_BITS'($past(scan_stat.push_n)))
		else $error("queue count lost pushed records");
`endif

endmodule
